### rtl/core/rvdec_pkg.sv
// Shared types and constants for the RV64I instruction decoder.
package rvdec_pkg;

    // Dense mnemonic numbering of the decoded instruction
    typedef enum logic [5:0] {
        MN_LUI    = 6'd0,
        MN_AUIPC  = 6'd1,
        MN_JAL    = 6'd2,
        MN_JALR   = 6'd3,
        MN_BEQ    = 6'd4,
        MN_BNE    = 6'd5,
        MN_BLT    = 6'd6,
        MN_BGE    = 6'd7,
        MN_BLTU   = 6'd8,
        MN_BGEU   = 6'd9,
        MN_LB     = 6'd10,
        MN_LH     = 6'd11,
        MN_LW     = 6'd12,
        MN_LD     = 6'd13,
        MN_LBU    = 6'd14,
        MN_LHU    = 6'd15,
        MN_LWU    = 6'd16,
        MN_SB     = 6'd17,
        MN_SH     = 6'd18,
        MN_SW     = 6'd19,
        MN_SD     = 6'd20,
        MN_ADDI   = 6'd21,
        MN_SLTI   = 6'd22,
        MN_SLTIU  = 6'd23,
        MN_XORI   = 6'd24,
        MN_ORI    = 6'd25,
        MN_ANDI   = 6'd26,
        MN_SLLI   = 6'd27,
        MN_SRLI   = 6'd28,
        MN_SRAI   = 6'd29,
        MN_ADD    = 6'd30,
        MN_SUB    = 6'd31,
        MN_SLL    = 6'd32,
        MN_SLT    = 6'd33,
        MN_SLTU   = 6'd34,
        MN_XOR    = 6'd35,
        MN_SRL    = 6'd36,
        MN_SRA    = 6'd37,
        MN_OR     = 6'd38,
        MN_AND    = 6'd39,
        MN_ECALL  = 6'd40,
        MN_EBREAK = 6'd41,
        MN_WFI    = 6'd42,
        MN_BR_X   = 6'd43,
        MN_LD_X   = 6'd44,
        MN_ST_X   = 6'd45,
        MN_OPI_X  = 6'd46,
        MN_OP_X   = 6'd47,
        MN_SYS_X  = 6'd48,
        MN_UNK    = 6'd49
    } t_mnem;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_ALT = 7'h20;

    // Exact system words
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_WFI    = 32'h1050_0073;

    typedef struct packed {
        t_mnem        code;
        logic [19:0]  imm;
        logic [63:0]  target;
    } t_dec_result;

endpackage

### rtl/core/rvdec_decode.sv
// Combinational classification, immediate selection and target add.
module rvdec_decode (
    input  logic [31:0]              i_instr_word,
    input  logic [63:0]              i_prog_counter,
    output rvdec_pkg::t_dec_result   o_result
);

    logic [6:0]       opc;
    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [19:0]      imm_i;
    logic [19:0]      imm_s;
    logic [19:0]      imm_u;
    logic [63:0]      off_b;
    logic [63:0]      off_j;
    logic             use_b;
    logic             use_j;
    rvdec_pkg::t_mnem code;
    logic [19:0]      imm;

    assign opc   = i_instr_word[6:0];
    assign f3    = i_instr_word[14:12];
    assign f7    = i_instr_word[31:25];
    assign imm_i = {{8{i_instr_word[31]}}, i_instr_word[31:20]};
    assign imm_s = {{8{i_instr_word[31]}}, i_instr_word[31:25], i_instr_word[11:7]};
    assign imm_u = i_instr_word[31:12];
    assign off_b = {{51{i_instr_word[31]}}, i_instr_word[31], i_instr_word[7],
                    i_instr_word[30:25], i_instr_word[11:8], 1'b0};
    assign off_j = {{43{i_instr_word[31]}}, i_instr_word[31], i_instr_word[19:12],
                    i_instr_word[20], i_instr_word[30:21], 1'b0};

    always_comb begin
        code  = rvdec_pkg::MN_UNK;
        imm   = '0;
        use_b = 1'b0;
        use_j = 1'b0;
        unique case (opc)
            rvdec_pkg::OPC_LUI: begin
                code = rvdec_pkg::MN_LUI;
                imm  = imm_u;
            end
            rvdec_pkg::OPC_AUIPC: begin
                code = rvdec_pkg::MN_AUIPC;
                imm  = imm_u;
            end
            rvdec_pkg::OPC_JAL: begin
                code  = rvdec_pkg::MN_JAL;
                use_j = 1'b1;
            end
            rvdec_pkg::OPC_JALR: begin
                // only funct3 zero is a real jalr
                if (f3 == 3'd0) begin
                    code = rvdec_pkg::MN_JALR;
                    imm  = imm_i;
                end
            end
            rvdec_pkg::OPC_BRANCH: begin
                use_b = 1'b1;
                unique case (f3)
                    3'd0:    code = rvdec_pkg::MN_BEQ;
                    3'd1:    code = rvdec_pkg::MN_BNE;
                    3'd4:    code = rvdec_pkg::MN_BLT;
                    3'd5:    code = rvdec_pkg::MN_BGE;
                    3'd6:    code = rvdec_pkg::MN_BLTU;
                    3'd7:    code = rvdec_pkg::MN_BGEU;
                    default: code = rvdec_pkg::MN_BR_X;
                endcase
            end
            rvdec_pkg::OPC_LOAD: begin
                imm = imm_i;
                unique case (f3)
                    3'd0:    code = rvdec_pkg::MN_LB;
                    3'd1:    code = rvdec_pkg::MN_LH;
                    3'd2:    code = rvdec_pkg::MN_LW;
                    3'd3:    code = rvdec_pkg::MN_LD;
                    3'd4:    code = rvdec_pkg::MN_LBU;
                    3'd5:    code = rvdec_pkg::MN_LHU;
                    3'd6:    code = rvdec_pkg::MN_LWU;
                    default: code = rvdec_pkg::MN_LD_X;
                endcase
            end
            rvdec_pkg::OPC_STORE: begin
                imm = imm_s;
                unique case (f3)
                    3'd0:    code = rvdec_pkg::MN_SB;
                    3'd1:    code = rvdec_pkg::MN_SH;
                    3'd2:    code = rvdec_pkg::MN_SW;
                    3'd3:    code = rvdec_pkg::MN_SD;
                    default: code = rvdec_pkg::MN_ST_X;
                endcase
            end
            rvdec_pkg::OPC_OPIMM: begin
                imm = imm_i;
                unique case (f3)
                    3'd0:    code = rvdec_pkg::MN_ADDI;
                    3'd1:    code = rvdec_pkg::MN_SLLI;
                    3'd2:    code = rvdec_pkg::MN_SLTI;
                    3'd3:    code = rvdec_pkg::MN_SLTIU;
                    3'd4:    code = rvdec_pkg::MN_XORI;
                    3'd5:    code = (f7 == rvdec_pkg::F7_ALT) ? rvdec_pkg::MN_SRAI
                                                              : rvdec_pkg::MN_SRLI;
                    3'd6:    code = rvdec_pkg::MN_ORI;
                    default: code = rvdec_pkg::MN_ANDI;
                endcase
            end
            rvdec_pkg::OPC_OP: begin
                if (f7 == 7'd0) begin
                    unique case (f3)
                        3'd0:    code = rvdec_pkg::MN_ADD;
                        3'd1:    code = rvdec_pkg::MN_SLL;
                        3'd2:    code = rvdec_pkg::MN_SLT;
                        3'd3:    code = rvdec_pkg::MN_SLTU;
                        3'd4:    code = rvdec_pkg::MN_XOR;
                        3'd5:    code = rvdec_pkg::MN_SRL;
                        3'd6:    code = rvdec_pkg::MN_OR;
                        default: code = rvdec_pkg::MN_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
                    code = rvdec_pkg::MN_SUB;
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
                    code = rvdec_pkg::MN_SRA;
                end else begin
                    code = rvdec_pkg::MN_OP_X;
                end
            end
            rvdec_pkg::OPC_SYSTEM: begin
                priority if (i_instr_word == rvdec_pkg::WORD_ECALL) begin
                    code = rvdec_pkg::MN_ECALL;
                end else if (i_instr_word == rvdec_pkg::WORD_EBREAK) begin
                    code = rvdec_pkg::MN_EBREAK;
                end else if (i_instr_word == rvdec_pkg::WORD_WFI) begin
                    code = rvdec_pkg::MN_WFI;
                end else begin
                    code = rvdec_pkg::MN_SYS_X;
                end
            end
            default: code = rvdec_pkg::MN_UNK;
        endcase
    end

    assign o_result.code   = code;
    assign o_result.imm    = imm;
    // one 64-bit add, wraps naturally
    assign o_result.target = (use_b || use_j)
                           ? i_prog_counter + (use_j ? off_j : off_b)
                           : 64'd0;

endmodule

### rtl/core/rv64i_instruction_decoder_unit.sv
// Top level of the RV64I instruction decoder: input register, decode, result register.
//
//  channel   direction  handshake           payload
//  request   in         start / busy        i_instr_word, i_prog_counter
//  result    out        o_valid (strobe)    o_mnemonic_code, o_dest_reg, o_src1_reg,
//                                           o_src2_reg, o_shown_immediate, o_jump_target
//
//  A request is taken every cycle; busy is always low.
//  Its result strobes after passing the input register, then the result register.
//  The decode and the 64-bit target add sit between the two registers.
//  Synchronous reset clears both valid flags; payload registers are not reset.
//  The receiver cannot stall, so nothing is ever held back.
module rv64i_instruction_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_instr_word,
    input  logic [63:0]         i_prog_counter,
    output logic                o_valid,
    output logic [5:0]          o_mnemonic_code,
    output logic [4:0]          o_dest_reg,
    output logic [4:0]          o_src1_reg,
    output logic [4:0]          o_src2_reg,
    output logic signed [19:0]  o_shown_immediate,
    output logic [63:0]         o_jump_target
);

    logic                   r_in_valid;
    logic [31:0]            r_instr;
    logic [63:0]            r_pc;
    logic                   r_out_valid;
    rvdec_pkg::t_dec_result r_result;
    logic [31:0]            r_out_instr;
    rvdec_pkg::t_dec_result n_result;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_instr     <= i_instr_word;
        r_pc        <= i_prog_counter;
        r_result    <= n_result;
        r_out_instr <= r_instr;
    end

    rvdec_decode u_decode (
        .i_instr_word   (r_instr),
        .i_prog_counter (r_pc),
        .o_result       (n_result)
    );

    assign o_valid           = r_out_valid;
    assign o_mnemonic_code   = r_result.code;
    assign o_dest_reg        = r_out_instr[11:7];
    assign o_src1_reg        = r_out_instr[19:15];
    assign o_src2_reg        = r_out_instr[24:20];
    assign o_shown_immediate = r_result.imm;
    assign o_jump_target     = r_result.target;

    // A result strobe always traces back to a request through the input and result registers
    a_strobe_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result strobe without a request");

    // Only branches and jal carry a target
    a_target_only_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_jump_target != 64'd0) |->
            (r_result.code == rvdec_pkg::MN_JAL  || r_result.code == rvdec_pkg::MN_BEQ ||
             r_result.code == rvdec_pkg::MN_BNE  || r_result.code == rvdec_pkg::MN_BLT ||
             r_result.code == rvdec_pkg::MN_BGE  || r_result.code == rvdec_pkg::MN_BLTU ||
             r_result.code == rvdec_pkg::MN_BGEU || r_result.code == rvdec_pkg::MN_BR_X))
        else $error("jump target on a non-flow instruction");

    // Jal, the reserved-branch catch-all and ecall show no immediate
    a_flow_no_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_result.code == rvdec_pkg::MN_JAL ||
                     r_result.code == rvdec_pkg::MN_BR_X ||
                     r_result.code == rvdec_pkg::MN_ECALL)) |->
            (o_shown_immediate == 20'sd0))
        else $error("immediate shown for jal, branch or ecall");

    // Op-imm catch-all is never produced
    a_no_opimm_catchall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_result.code != rvdec_pkg::MN_OPI_X))
        else $error("op-imm catch-all code produced");

endmodule

### test/rv64i_decode_checker.sv
// Checker for the RV64I decoder: predicts each request's decode and compares the result strobes.
`timescale 1ns / 1ps

module rv64i_decode_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [31:0]         i_instr_word,
    input  logic [63:0]         i_prog_counter,
    input  logic                i_valid,
    input  logic [5:0]          i_mnemonic_code,
    input  logic [4:0]          i_dest_reg,
    input  logic [4:0]          i_src1_reg,
    input  logic [4:0]          i_src2_reg,
    input  logic signed [19:0]  i_shown_immediate,
    input  logic [63:0]         i_jump_target,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        rvdec_pkg::t_mnem code;
        logic [4:0]       rd;
        logic [4:0]       rs1;
        logic [4:0]       rs2;
        logic [19:0]      imm;
        logic [63:0]      target;
    } t_decoded_instr;

    t_decoded_instr decode_q[$];

    function automatic t_decoded_instr decode_instr(input logic [31:0] w,
                                                    input logic [63:0] pc);
        t_decoded_instr d;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [19:0] imm_i;
        logic [19:0] imm_s;
        logic [63:0] off_b;
        logic [63:0] off_j;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{8{w[31]}}, w[31:20]};
        imm_s = {{8{w[31]}}, w[31:25], w[11:7]};
        off_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        off_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.code   = rvdec_pkg::MN_UNK;
        d.rd     = w[11:7];
        d.rs1    = w[19:15];
        d.rs2    = w[24:20];
        d.imm    = '0;
        d.target = '0;
        case (opc)
            rvdec_pkg::OPC_LUI: begin
                d.code = rvdec_pkg::MN_LUI;
                d.imm  = w[31:12];
            end
            rvdec_pkg::OPC_AUIPC: begin
                d.code = rvdec_pkg::MN_AUIPC;
                d.imm  = w[31:12];
            end
            rvdec_pkg::OPC_JAL: begin
                d.code   = rvdec_pkg::MN_JAL;
                d.target = pc + off_j;
            end
            rvdec_pkg::OPC_JALR: begin
                // nonzero funct3 falls through to unknown with no immediate
                if (f3 == 3'd0) begin
                    d.code = rvdec_pkg::MN_JALR;
                    d.imm  = imm_i;
                end
            end
            rvdec_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0:    d.code = rvdec_pkg::MN_BEQ;
                    3'd1:    d.code = rvdec_pkg::MN_BNE;
                    3'd4:    d.code = rvdec_pkg::MN_BLT;
                    3'd5:    d.code = rvdec_pkg::MN_BGE;
                    3'd6:    d.code = rvdec_pkg::MN_BLTU;
                    3'd7:    d.code = rvdec_pkg::MN_BGEU;
                    default: d.code = rvdec_pkg::MN_BR_X;
                endcase
                d.target = pc + off_b;
            end
            rvdec_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0:    d.code = rvdec_pkg::MN_LB;
                    3'd1:    d.code = rvdec_pkg::MN_LH;
                    3'd2:    d.code = rvdec_pkg::MN_LW;
                    3'd3:    d.code = rvdec_pkg::MN_LD;
                    3'd4:    d.code = rvdec_pkg::MN_LBU;
                    3'd5:    d.code = rvdec_pkg::MN_LHU;
                    3'd6:    d.code = rvdec_pkg::MN_LWU;
                    default: d.code = rvdec_pkg::MN_LD_X;
                endcase
                d.imm = imm_i;
            end
            rvdec_pkg::OPC_STORE: begin
                case (f3)
                    3'd0:    d.code = rvdec_pkg::MN_SB;
                    3'd1:    d.code = rvdec_pkg::MN_SH;
                    3'd2:    d.code = rvdec_pkg::MN_SW;
                    3'd3:    d.code = rvdec_pkg::MN_SD;
                    default: d.code = rvdec_pkg::MN_ST_X;
                endcase
                d.imm = imm_s;
            end
            rvdec_pkg::OPC_OPIMM: begin
                case (f3)
                    3'd0:    d.code = rvdec_pkg::MN_ADDI;
                    3'd1:    d.code = rvdec_pkg::MN_SLLI;
                    3'd2:    d.code = rvdec_pkg::MN_SLTI;
                    3'd3:    d.code = rvdec_pkg::MN_SLTIU;
                    3'd4:    d.code = rvdec_pkg::MN_XORI;
                    3'd5:    d.code = (f7 == rvdec_pkg::F7_ALT) ? rvdec_pkg::MN_SRAI
                                                                : rvdec_pkg::MN_SRLI;
                    3'd6:    d.code = rvdec_pkg::MN_ORI;
                    default: d.code = rvdec_pkg::MN_ANDI;
                endcase
                d.imm = imm_i;
            end
            rvdec_pkg::OPC_OP: begin
                if (f7 == 7'h00) begin
                    case (f3)
                        3'd0:    d.code = rvdec_pkg::MN_ADD;
                        3'd1:    d.code = rvdec_pkg::MN_SLL;
                        3'd2:    d.code = rvdec_pkg::MN_SLT;
                        3'd3:    d.code = rvdec_pkg::MN_SLTU;
                        3'd4:    d.code = rvdec_pkg::MN_XOR;
                        3'd5:    d.code = rvdec_pkg::MN_SRL;
                        3'd6:    d.code = rvdec_pkg::MN_OR;
                        default: d.code = rvdec_pkg::MN_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
                    d.code = rvdec_pkg::MN_SUB;
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
                    d.code = rvdec_pkg::MN_SRA;
                end else begin
                    d.code = rvdec_pkg::MN_OP_X;
                end
            end
            rvdec_pkg::OPC_SYSTEM: begin
                if (w == rvdec_pkg::WORD_ECALL)       d.code = rvdec_pkg::MN_ECALL;
                else if (w == rvdec_pkg::WORD_EBREAK) d.code = rvdec_pkg::MN_EBREAK;
                else if (w == rvdec_pkg::WORD_WFI)    d.code = rvdec_pkg::MN_WFI;
                else                                  d.code = rvdec_pkg::MN_SYS_X;
            end
            default: d.code = rvdec_pkg::MN_UNK;
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_decoded_instr want;
        if (!i_rst_n) begin
            decode_q.delete();
        end else begin
            // check the result first so a request accepted this edge is not matched by it
            if (i_valid) begin
                if (decode_q.size() == 0) begin
                    report_mismatch("result with no request pending", i_mnemonic_code, '0);
                end else begin
                    want = decode_q.pop_front();
                    if (i_mnemonic_code !== want.code)
                        report_mismatch("mnemonic_code", i_mnemonic_code, want.code);
                    if (i_dest_reg !== want.rd)
                        report_mismatch("dest_reg", i_dest_reg, want.rd);
                    if (i_src1_reg !== want.rs1)
                        report_mismatch("src1_reg", i_src1_reg, want.rs1);
                    if (i_src2_reg !== want.rs2)
                        report_mismatch("src2_reg", i_src2_reg, want.rs2);
                    if (i_shown_immediate !== want.imm)
                        report_mismatch("shown_immediate", i_shown_immediate, want.imm);
                    if (i_jump_target !== want.target)
                        report_mismatch("jump_target", i_jump_target, want.target);
                end
            end
            if (i_start && !i_busy)
                decode_q.push_back(decode_instr(i_instr_word, i_prog_counter));
        end
        o_pending = decode_q.size();
    end

endmodule

### test/rv64i_instruction_decoder_unit_tb.sv
// Testbench top for the RV64I decoder: clock, reset, directed and random requests, verdict.
`timescale 1ns / 1ps

module rv64i_instruction_decoder_unit_tb;

    localparam int RANDOM_ITEMS = 600;
    localparam int NUM_PHASES   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_instr_word;
    logic [63:0]        i_prog_counter;
    logic               o_valid;
    logic [5:0]         o_mnemonic_code;
    logic [4:0]         o_dest_reg;
    logic [4:0]         o_src1_reg;
    logic [4:0]         o_src2_reg;
    logic signed [19:0] o_shown_immediate;
    logic [63:0]        o_jump_target;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 idle_pct;

    rv64i_instruction_decoder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_instr_word      (i_instr_word),
        .i_prog_counter    (i_prog_counter),
        .o_valid           (o_valid),
        .o_mnemonic_code   (o_mnemonic_code),
        .o_dest_reg        (o_dest_reg),
        .o_src1_reg        (o_src1_reg),
        .o_src2_reg        (o_src2_reg),
        .o_shown_immediate (o_shown_immediate),
        .o_jump_target     (o_jump_target)
    );

    rv64i_decode_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_instr_word      (i_instr_word),
        .i_prog_counter    (i_prog_counter),
        .i_valid           (o_valid),
        .i_mnemonic_code   (o_mnemonic_code),
        .i_dest_reg        (o_dest_reg),
        .i_src1_reg        (o_src1_reg),
        .i_src2_reg        (o_src2_reg),
        .i_shown_immediate (o_shown_immediate),
        .i_jump_target     (o_jump_target),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_pc();
        logic [63:0] pc;
        pc = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       pc = {52'hFFFF_FFFF_FFFF_F, pc[11:0]};
            1:       pc = {52'h0, pc[11:0]};
            default: pc = pc;
        endcase
        return pc;
    endfunction

    // mostly legal encodings with random fields, some raw noise
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(99) < 88) begin
            case ($urandom_range(9))
                0: w[6:0] = rvdec_pkg::OPC_LUI;
                1: w[6:0] = rvdec_pkg::OPC_AUIPC;
                2: w[6:0] = rvdec_pkg::OPC_JAL;
                3: begin
                    w[6:0] = rvdec_pkg::OPC_JALR;
                    if ($urandom_range(3) != 0) w[14:12] = 3'd0;
                end
                4: w[6:0] = rvdec_pkg::OPC_BRANCH;
                5: w[6:0] = rvdec_pkg::OPC_LOAD;
                6: w[6:0] = rvdec_pkg::OPC_STORE;
                7: begin
                    w[6:0] = rvdec_pkg::OPC_OPIMM;
                    if (w[14:12] == 3'd5 && $urandom_range(1) == 0)
                        w[31:25] = rvdec_pkg::F7_ALT;
                end
                8: begin
                    w[6:0] = rvdec_pkg::OPC_OP;
                    case ($urandom_range(9))
                        0, 1, 2, 3: w[31:25] = 7'h00;
                        4, 5, 6:    w[31:25] = rvdec_pkg::F7_ALT;
                        default:    w[31:25] = w[31:25];
                    endcase
                end
                default: begin
                    w[6:0] = rvdec_pkg::OPC_SYSTEM;
                    case ($urandom_range(5))
                        0:       w = rvdec_pkg::WORD_ECALL;
                        1:       w = rvdec_pkg::WORD_EBREAK;
                        2:       w = rvdec_pkg::WORD_WFI;
                        default: w = w;
                    endcase
                end
            endcase
        end
        return w;
    endfunction

    task automatic send_request(input logic [31:0] w, input logic [63:0] pc);
        start          <= 1'b1;
        i_instr_word   <= w;
        i_prog_counter <= pc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // hold off the next request for a random gap
        while ($urandom_range(99) < idle_pct) begin
            start          <= 1'b0;
            i_instr_word   <= $urandom;
            i_prog_counter <= {$urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int phase_pct[NUM_PHASES];
        phase_pct = '{0, 82, 0, 36};
        idle_pct       = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_instr_word   = '0;
        i_prog_counter = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(32'hFFFF_F037, 64'h0);                     // lui, upper immediate all ones
        send_request(32'h8000_0017, 64'h1234_5678_9ABC_DEF0);   // auipc
        send_request(32'h8000_006F, 64'h0);                     // jal, wraps below zero
        send_request(32'h7FFF_F0EF, 64'hFFFF_FFFF_FFFF_FFFF);   // jal, wraps past the top
        send_request(32'hFFF0_8067, 64'h100);                   // jalr
        send_request(32'h0000_1067, 64'h100);                   // jalr with bad funct3
        send_request(32'h7E00_0FE3, 64'hFFFF_FFFF_FFFF_FFF0);   // beq, largest offset
        send_request(32'h8000_2063, 64'h0);                     // reserved branch funct3
        send_request(32'h8000_7063, 64'h8000_0000_0000_0000);   // bgeu, most negative offset
        send_request(32'h8000_7003, 64'h0);                     // reserved load funct3
        send_request(32'h0000_4023, 64'h0);                     // reserved store funct3
        send_request(32'hFE00_0FA3, 64'h0);                     // sb, store offset -1
        send_request(32'h4000_5013, 64'h0);                     // srai
        send_request(32'h4200_5013, 64'h0);                     // srli with odd funct7
        send_request(32'hFE00_1013, 64'h0);                     // slli ignores funct7
        send_request(32'h4000_0033, 64'h0);                     // sub
        send_request(32'h4000_5033, 64'h0);                     // sra
        send_request(32'h0200_0033, 64'h0);                     // unlisted op pair
        send_request(rvdec_pkg::WORD_ECALL, 64'h0);
        send_request(rvdec_pkg::WORD_EBREAK, 64'h0);
        send_request(rvdec_pkg::WORD_WFI, 64'h0);
        send_request(32'h0020_0073, 64'h0);                     // other system word
        send_request(32'h0000_000B, 64'h0);                     // unlisted opcode
        send_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(32'h0000_0000, 64'h0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) begin
                // keep a stretch of back-to-back requests in every phase
                idle_pct = (k % 50 < 10) ? 0 : phase_pct[ph];
                send_request(rand_instr(), rand_pc());
            end
        end
        start <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/rvdec_pkg.sv
rtl/core/rvdec_decode.sv
rtl/core/rv64i_instruction_decoder_unit.sv
test/rv64i_decode_checker.sv
test/rv64i_instruction_decoder_unit_tb.sv
